[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is low.
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker assertion failed");

// Check a property on every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("checker assertion failed during or after reset");

`endif

[rtl/rty_pkg.sv]
// ----------------------------------------------------------------------------
// rty_pkg
// Shared types and constants of the RGB to planar YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rty_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SWAP_RB      = 2'd2,
        CFG_FLIP_VERT    = 2'd3
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd352;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd288;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int LUMA_OFF_W = 24;
    localparam int CHR_OFF_W  = 25;

    // Pixel lanes per transfer
    localparam int LANES = 2;

    // Load enables of the three pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

[rtl/rty_if.sv]
// ----------------------------------------------------------------------------
// rty_if
// Valid/ready channels of the converter: pixel pairs, YUV results, config.
// ----------------------------------------------------------------------------
interface rty_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_ch0;
    logic [7:0] first_ch1;
    logic [7:0] first_ch2;
    logic [7:0] second_ch0;
    logic [7:0] second_ch1;
    logic [7:0] second_ch2;

    modport source (
        output valid, first_ch0, first_ch1, first_ch2,
        output second_ch0, second_ch1, second_ch2,
        input  ready
    );
    modport sink (
        input  valid, first_ch0, first_ch1, first_ch2,
        input  second_ch0, second_ch1, second_ch2,
        output ready
    );
endinterface

interface rty_yuv_if;
    logic        valid;
    logic        ready;
    logic [7:0]  luma_first;
    logic [7:0]  luma_second;
    logic [23:0] luma_offset;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic [24:0] cb_offset;
    logic [24:0] cr_offset;
    logic        chroma_valid;
    logic        frame_last;

    modport source (
        output valid, luma_first, luma_second, luma_offset,
        output chroma_blue, chroma_red, cb_offset, cr_offset,
        output chroma_valid, frame_last,
        input  ready
    );
    modport sink (
        input  valid, luma_first, luma_second, luma_offset,
        input  chroma_blue, chroma_red, cb_offset, cr_offset,
        input  chroma_valid, frame_last,
        output ready
    );
endinterface

interface rty_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/rty_lane.sv]
// ----------------------------------------------------------------------------
// rty_lane
// One pixel lane: RGB to Y, Cb, Cr with integer weights and divide by 100.
// ----------------------------------------------------------------------------
module rty_lane (
    input  logic              clk,
    input  rty_pkg::stage_en_t en,
    input  logic              swap_red_blue,
    input  logic [7:0]        ch0,
    input  logic [7:0]        ch1,
    input  logic [7:0]        ch2,
    output logic [7:0]        luma,
    output logic [7:0]        cb,
    output logic [7:0]        cr
);

    localparam int SUM_W    = 15;
    localparam int PROD_W   = 28;
    localparam int RECIP    = 5243;   // ceil(2^19 / 100), exact for sums below 2^15
    localparam int RECIP_SH = 19;
    localparam int BIAS     = 12800;

    // Divide a weighted sum by 100 through a reciprocal multiply
    function automatic logic [7:0] div100(input logic [SUM_W-1:0] n);
        logic [PROD_W-1:0] p;
        p = PROD_W'(n) * PROD_W'(RECIP);
        return p[RECIP_SH+7:RECIP_SH];
    endfunction

    logic [7:0] red;
    logic [7:0] blue;

    logic [SUM_W-1:0] yr_reg, yg_reg, yb_reg;
    logic [SUM_W-1:0] ur_reg, ug_reg, ub_reg;
    logic [SUM_W-1:0] vr_reg, vg_reg, vb_reg;
    logic [SUM_W-1:0] sy_reg, su_reg, sv_reg;
    logic [7:0]       luma_reg, cb_reg, cr_reg;

    // Pick red and blue from the channel order
    assign red  = swap_red_blue ? ch2 : ch0;
    assign blue = swap_red_blue ? ch0 : ch2;

    // Stage 1: weight each color channel
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            yr_reg <= SUM_W'(red)  * SUM_W'(30);
            yg_reg <= SUM_W'(ch1)  * SUM_W'(59);
            yb_reg <= SUM_W'(blue) * SUM_W'(11);
            ur_reg <= SUM_W'(red)  * SUM_W'(17);
            ug_reg <= SUM_W'(ch1)  * SUM_W'(33);
            ub_reg <= SUM_W'(blue) * SUM_W'(50);
            vr_reg <= SUM_W'(red)  * SUM_W'(50);
            vg_reg <= SUM_W'(ch1)  * SUM_W'(42);
            vb_reg <= SUM_W'(blue) * SUM_W'(8);
        end
    end

    // Stage 2: add up the weighted terms; chroma sums never go negative
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            sy_reg <= yr_reg + yg_reg + yb_reg;
            su_reg <= SUM_W'(BIAS) + ub_reg - ur_reg - ug_reg;
            sv_reg <= SUM_W'(BIAS) + vr_reg - vg_reg - vb_reg;
        end
    end

    // Stage 3: scale down by 100
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            luma_reg <= div100(sy_reg);
            cb_reg   <= div100(su_reg);
            cr_reg   <= div100(sv_reg);
        end
    end

    assign luma = luma_reg;
    assign cb   = cb_reg;
    assign cr   = cr_reg;

endmodule

[rtl/rty_addr.sv]
// ----------------------------------------------------------------------------
// rty_addr
// Raster counters and planar frame offsets of each pixel pair.
// ----------------------------------------------------------------------------
module rty_addr #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rty_pkg::stage_en_t en,
    input  logic               accept,
    input  logic [12:0]        frame_width,
    input  logic [12:0]        frame_height,
    input  logic               flip_vertical,
    output logic [23:0]        luma_offset,
    output logic [24:0]        cb_offset,
    output logic [24:0]        cr_offset,
    output logic               chroma_valid,
    output logic               frame_last
);

    localparam int PAIRS_MAX = MAX_WIDTH / 2;
    localparam int PW   = $clog2(PAIRS_MAX + 1);
    localparam int CW   = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW   = PW + 1;
    localparam int PLW  = WW + HW;
    localparam int YPW  = RW + WW;
    localparam int CPW  = RW + PW;
    localparam int CMPW = 15;

    logic [11:0]   pairs_raw;
    logic [PW-1:0] pairs;
    logic [HW-1:0] height;
    logic [WW-1:0] width;

    logic [CW-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0] row_reg, row_next, row_eff;
    logic [RW-1:0] oy;
    logic          last_col, last_row, cv;

    logic [RW-1:0]  oy_s1_reg;
    logic [CW-1:0]  col_s1_reg;
    logic [WW-1:0]  w_s1_reg;
    logic [PW-1:0]  pairs_s1_reg;
    logic [PLW-1:0] plane_s1_reg;
    logic           cv_s1_reg, last_s1_reg;

    logic [YPW-1:0] yprod_s2_reg;
    logic [CPW-1:0] cprod_s2_reg;
    logic [PLW-1:0] plane_s2_reg;
    logic [PLW:0]   plane_hi_s2_reg;
    logic [CW-1:0]  col_s2_reg;
    logic           cv_s2_reg, last_s2_reg;

    logic [23:0] luma_off_reg;
    logic [24:0] cb_off_reg, cr_off_reg;
    logic        cv_s3_reg, last_s3_reg;

    // Clamp the frame size to the supported range
    assign pairs_raw = frame_width[12:1];

    always_comb
    begin
        if (pairs_raw == '0)
            pairs = PW'(1);
        else if (CMPW'(pairs_raw) > CMPW'(PAIRS_MAX))
            pairs = PW'(PAIRS_MAX);
        else
            pairs = PW'(pairs_raw);

        if (frame_height == '0)
            height = HW'(1);
        else if (CMPW'(frame_height) > CMPW'(MAX_HEIGHT))
            height = HW'(MAX_HEIGHT);
        else
            height = HW'(frame_height);
    end

    assign width = {pairs, 1'b0};

    // Treat a counter beyond its limit as zero, then map the output row
    always_comb
    begin
        col_eff  = (CMPW'(col_reg) >= CMPW'(pairs)) ? '0 : col_reg;
        row_eff  = (CMPW'(row_reg) >= CMPW'(height)) ? '0 : row_reg;
        last_col = (CMPW'(col_eff) == CMPW'(pairs) - CMPW'(1));
        last_row = (CMPW'(row_eff) == CMPW'(height) - CMPW'(1));
        oy       = flip_vertical ? RW'(height - HW'(1) - HW'(row_eff)) : row_eff;
        cv       = oy[0] | ((CMPW'(oy) == CMPW'(height) - CMPW'(1)) & height[0]);
    end

    // Advance column, wrap to the next row and to the next frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_eff + RW'(1);
            end
            else
            begin
                col_next = col_eff + CW'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: position and plane size
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            oy_s1_reg    <= oy;
            col_s1_reg   <= col_eff;
            w_s1_reg     <= width;
            pairs_s1_reg <= pairs;
            plane_s1_reg <= PLW'(width) * PLW'(height);
            cv_s1_reg    <= cv;
            last_s1_reg  <= last_col & last_row;
        end
    end

    // Stage 2: row products and the start of the V plane
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            yprod_s2_reg    <= YPW'(oy_s1_reg) * YPW'(w_s1_reg);
            cprod_s2_reg    <= CPW'(oy_s1_reg >> 1) * CPW'(pairs_s1_reg);
            plane_s2_reg    <= plane_s1_reg;
            plane_hi_s2_reg <= (PLW+1)'(plane_s1_reg) + (PLW+1)'(plane_s1_reg >> 2);
            col_s2_reg      <= col_s1_reg;
            cv_s2_reg       <= cv_s1_reg;
            last_s2_reg     <= last_s1_reg;
        end
    end

    // Stage 3: final offsets, masked to the field widths
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            luma_off_reg <= 24'(32'(yprod_s2_reg) + 32'({col_s2_reg, 1'b0}));
            cb_off_reg   <= 25'(32'(plane_s2_reg) + 32'(cprod_s2_reg) + 32'(col_s2_reg));
            cr_off_reg   <= 25'(32'(plane_hi_s2_reg) + 32'(cprod_s2_reg)
                                + 32'(col_s2_reg));
            cv_s3_reg    <= cv_s2_reg;
            last_s3_reg  <= last_s2_reg;
        end
    end

    assign luma_offset  = luma_off_reg;
    assign cb_offset    = cb_off_reg;
    assign cr_offset    = cr_off_reg;
    assign chroma_valid = cv_s3_reg;
    assign frame_last   = last_s3_reg;

endmodule

[rtl/rgb_to_yuv420p_planar.sv]
// ----------------------------------------------------------------------------
// rgb_to_yuv420p_planar
// RGB pixel pairs in, luma/chroma bytes and planar YUV 4:2:0 offsets out.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  carries one horizontal pixel pair per transfer, raster order.
//   yuv_out carries two Y bytes, one Cb/Cr pair taken from the second pixel,
//           the byte offsets of Y, U and V in the frame, chroma_valid (the
//           row whose chroma is final) and frame_last (last pair of frame).
//   cfg     writes frame_width, frame_height, swap_red_blue, flip_vertical by
//           index; it is always ready. Write it only while the block is idle.
// A pix_in transfer reaches yuv_out through stages 1, 2 and 3. The block
// takes one pair per cycle unless yuv_out stalls: two color lanes and
// the offset path run as three-stage pipelines, with the lanes merged in
// the output register. Reset clears the column/row counters and the
// pipeline, and restores 352x288, no swap, no flip. When yuv_out stalls the
// held result stays and pix_in keeps accepting until the empty pipeline
// stages are filled, then ready drops until the output is taken.
// ----------------------------------------------------------------------------
module rgb_to_yuv420p_planar #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    rty_pix_if.sink      pix_in,
    rty_yuv_if.source    yuv_out,
    rty_cfg_if.sink      cfg
);

    logic [12:0] frame_width_reg, frame_height_reg;
    logic        swap_reg, flip_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;
    logic               accept;
    rty_pkg::stage_en_t en;

    logic [7:0] lane_ch0  [rty_pkg::LANES];
    logic [7:0] lane_ch1  [rty_pkg::LANES];
    logic [7:0] lane_ch2  [rty_pkg::LANES];
    logic [7:0] lane_luma [rty_pkg::LANES];
    logic [7:0] lane_cb   [rty_pkg::LANES];
    logic [7:0] lane_cr   [rty_pkg::LANES];

    // Take configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rty_pkg::WIDTH_RESET;
            frame_height_reg <= rty_pkg::HEIGHT_RESET;
            swap_reg         <= 1'b0;
            flip_reg         <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rty_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                rty_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                rty_pkg::CFG_SWAP_RB:      swap_reg         <= cfg.data[0];
                rty_pkg::CFG_FLIP_VERT:    flip_reg         <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Advance each stage when the one after it has room
    assign rdy3   = !v3_reg || yuv_out.ready;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign accept = pix_in.valid && rdy1;

    assign pix_in.ready = rdy1;
    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= pix_in.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Split the pair across the color lanes
    assign lane_ch0[0] = pix_in.first_ch0;
    assign lane_ch1[0] = pix_in.first_ch1;
    assign lane_ch2[0] = pix_in.first_ch2;
    assign lane_ch0[1] = pix_in.second_ch0;
    assign lane_ch1[1] = pix_in.second_ch1;
    assign lane_ch2[1] = pix_in.second_ch2;

    for (genvar i = 0; i < rty_pkg::LANES; i++)
    begin : g_lane
        rty_lane u_lane (
            .clk           (clk),
            .en            (en),
            .swap_red_blue (swap_reg),
            .ch0           (lane_ch0[i]),
            .ch1           (lane_ch1[i]),
            .ch2           (lane_ch2[i]),
            .luma          (lane_luma[i]),
            .cb            (lane_cb[i]),
            .cr            (lane_cr[i])
        );
    end

    // Offsets, counters and row flags
    rty_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .accept        (accept),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .flip_vertical (flip_reg),
        .luma_offset   (yuv_out.luma_offset),
        .cb_offset     (yuv_out.cb_offset),
        .cr_offset     (yuv_out.cr_offset),
        .chroma_valid  (yuv_out.chroma_valid),
        .frame_last    (yuv_out.frame_last)
    );

    // Merge the lanes: both lumas, chroma from the second pixel
    assign yuv_out.valid       = v3_reg;
    assign yuv_out.luma_first  = lane_luma[0];
    assign yuv_out.luma_second = lane_luma[1];
    assign yuv_out.chroma_blue = (lane_cb[0] & 8'h00) | lane_cb[1];
    assign yuv_out.chroma_red  = (lane_cr[0] & 8'h00) | lane_cr[1];

endmodule

[rtl/rty_checker.sv]
// ----------------------------------------------------------------------------
// rty_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rty_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  luma_first,
    input logic [23:0] luma_offset,
    input logic [24:0] cb_offset,
    input logic        frame_last
);

    // A stalled result holds its payload
    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(luma_first) && $stable(luma_offset) && $stable(cb_offset) && $stable(frame_last))

    // Pairs start on even columns of an even-width row
    `CHK_ASSERT(a_luma_even, clk, rst_n, out_valid |-> !luma_offset[0])

    // Reset empties the output register
    `CHK_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind rgb_to_yuv420p_planar rty_checker u_rty_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (yuv_out.valid),
    .out_ready   (yuv_out.ready),
    .luma_first  (yuv_out.luma_first),
    .luma_offset (yuv_out.luma_offset),
    .cb_offset   (yuv_out.cb_offset),
    .frame_last  (yuv_out.frame_last)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB to planar YUV 4:2:0 converter. A scoreboard
// class tracks frame geometry and the column/row position, predicts every
// result from each accepted pixel pair, and compares it with the output.
// Directed pairs hit color extremes and geometry corner cases. Random phases
// then mix configurations, sender gaps, receiver stalls and long back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W        = rty_pkg::PIX_W;
    localparam int LUMA_OFF_W   = rty_pkg::LUMA_OFF_W;
    localparam int CHR_OFF_W    = rty_pkg::CHR_OFF_W;
    localparam int CFG_DATA_W   = rty_pkg::CFG_DATA_W;
    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int PHASE_PAIRS  = 75;
    localparam int PHASE_COUNT  = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 120;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] first_ch0;
        logic [PIX_W-1:0] first_ch1;
        logic [PIX_W-1:0] first_ch2;
        logic [PIX_W-1:0] second_ch0;
        logic [PIX_W-1:0] second_ch1;
        logic [PIX_W-1:0] second_ch2;
    } pix_pair_t;

    typedef struct packed {
        logic [PIX_W-1:0]      luma_first;
        logic [PIX_W-1:0]      luma_second;
        logic [LUMA_OFF_W-1:0] luma_offset;
        logic [PIX_W-1:0]      chroma_blue;
        logic [PIX_W-1:0]      chroma_red;
        logic [CHR_OFF_W-1:0]  cb_offset;
        logic [CHR_OFF_W-1:0]  cr_offset;
        logic                  chroma_valid;
        logic                  frame_last;
    } yuv_result_t;

    // Frame position tracker and expected output store
    class yuv420_tracker;
        logic [CFG_DATA_W-1:0] frame_w;
        logic [CFG_DATA_W-1:0] frame_h;
        bit                    swap_rb;
        bit                    flip_v;
        int unsigned           col_count;
        int unsigned           row_count;
        yuv_result_t           expected_yuv[$];
        int                    failures;
        int                    pairs_seen;
        int                    results_checked;
        int                    frame_ends;
        int                    chroma_rows;
        int                    reg_writes;

        function new();
            frame_w   = rty_pkg::WIDTH_RESET;
            frame_h   = rty_pkg::HEIGHT_RESET;
            swap_rb   = 1'b0;
            flip_v    = 1'b0;
            col_count = 0;
            row_count = 0;
        endfunction

        function void write_register(rty_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            case (idx)
                rty_pkg::CFG_FRAME_WIDTH:  frame_w = value;
                rty_pkg::CFG_FRAME_HEIGHT: frame_h = value;
                rty_pkg::CFG_SWAP_RB:      swap_rb = value[0];
                rty_pkg::CFG_FLIP_VERT:    flip_v  = value[0];
                default:                   ;
            endcase
        endfunction

        // Convert one pair at the current position, then advance the position
        function yuv_result_t predict_pair(pix_pair_t p);
            int unsigned pairs, rows, w, col, row, oy, plane, co;
            int          ch0 [2];
            int          ch1 [2];
            int          ch2 [2];
            int          lum [2];
            int          red, blue, cb, cr;
            yuv_result_t res;

            ch0[0] = p.first_ch0;
            ch1[0] = p.first_ch1;
            ch2[0] = p.first_ch2;
            ch0[1] = p.second_ch0;
            ch1[1] = p.second_ch1;
            ch2[1] = p.second_ch2;

            // Clamp geometry: odd width rounds down, zero size means one
            pairs = frame_w >> 1;
            if (pairs == 0)
                pairs = 1;
            if (pairs > MAX_WIDTH / 2)
                pairs = MAX_WIDTH / 2;
            rows = frame_h;
            if (rows == 0)
                rows = 1;
            if (rows > MAX_HEIGHT)
                rows = MAX_HEIGHT;
            w = pairs * 2;

            // A position beyond a shrunken frame restarts at zero
            col = (col_count >= pairs) ? 0 : col_count;
            row = (row_count >= rows) ? 0 : row_count;

            cb = 0;
            cr = 0;
            for (int k = 0; k < 2; k++)
            begin
                red  = swap_rb ? ch2[k] : ch0[k];
                blue = swap_rb ? ch0[k] : ch2[k];
                lum[k] = (30 * red + 59 * ch1[k] + 11 * blue) / 100;
                cb = (-17 * red - 33 * ch1[k] + 50 * blue + 12800) / 100;
                cr = (50 * red - 42 * ch1[k] - 8 * blue + 12800) / 100;
            end

            oy    = flip_v ? (rows - 1 - row) : row;
            plane = w * rows;
            co    = (oy >> 1) * pairs + col;

            res.luma_first   = PIX_W'(lum[0]);
            res.luma_second  = PIX_W'(lum[1]);
            res.luma_offset  = LUMA_OFF_W'(oy * w + col * 2);
            res.chroma_blue  = PIX_W'(cb);
            res.chroma_red   = PIX_W'(cr);
            res.cb_offset    = CHR_OFF_W'(plane + co);
            res.cr_offset    = CHR_OFF_W'(plane + (plane >> 2) + co);
            res.chroma_valid = (oy % 2 == 1) || (oy == rows - 1 && rows % 2 == 1);
            res.frame_last   = (col == pairs - 1) && (row == rows - 1);

            col++;
            if (col >= pairs)
            begin
                col = 0;
                row++;
                if (row >= rows)
                    row = 0;
            end
            col_count = col;
            row_count = row;
            return res;
        endfunction

        function void note_pair(pix_pair_t p);
            yuv_result_t res;
            res = predict_pair(p);
            pairs_seen++;
            if (res.frame_last)
                frame_ends++;
            if (res.chroma_valid)
                chroma_rows++;
            expected_yuv.push_back(res);
        endfunction

        function string describe(yuv_result_t r);
            return $sformatf("Y=%0d/%0d yoff=%0d cb=%0d cr=%0d cboff=%0d croff=%0d cv=%0b last=%0b",
                             r.luma_first, r.luma_second, r.luma_offset, r.chroma_blue,
                             r.chroma_red, r.cb_offset, r.cr_offset, r.chroma_valid,
                             r.frame_last);
        endfunction

        function void check_yuv(yuv_result_t got);
            yuv_result_t want;
            if (expected_yuv.size() == 0)
            begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                    $display("ERROR: unexpected result %s", describe(got));
                return;
            end
            want = expected_yuv.pop_front();
            results_checked++;
            if (got !== want)
            begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                begin
                    $display("ERROR: result %0d mismatch", results_checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return expected_yuv.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rty_pix_if pix_bus ();
    rty_yuv_if yuv_bus ();
    rty_cfg_if cfg_bus ();

    yuv420_tracker tracker = new();

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    rgb_to_yuv420p_planar #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_bus),
        .yuv_out (yuv_bus),
        .cfg     (cfg_bus)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off when requested
    initial
    begin
        yuv_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                yuv_bus.ready <= 1'b0;
            end
            else
                yuv_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: apply register writes, note inputs, check results
    always @(posedge clk)
    begin : monitor_blk
        pix_pair_t   pp;
        yuv_result_t res;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                tracker.write_register(rty_pkg::cfg_idx_t'(cfg_bus.index), cfg_bus.data);
            if (pix_bus.valid && pix_bus.ready)
            begin
                pp.first_ch0  = pix_bus.first_ch0;
                pp.first_ch1  = pix_bus.first_ch1;
                pp.first_ch2  = pix_bus.first_ch2;
                pp.second_ch0 = pix_bus.second_ch0;
                pp.second_ch1 = pix_bus.second_ch1;
                pp.second_ch2 = pix_bus.second_ch2;
                tracker.note_pair(pp);
            end
            if (yuv_bus.valid && yuv_bus.ready)
            begin
                res.luma_first   = yuv_bus.luma_first;
                res.luma_second  = yuv_bus.luma_second;
                res.luma_offset  = yuv_bus.luma_offset;
                res.chroma_blue  = yuv_bus.chroma_blue;
                res.chroma_red   = yuv_bus.chroma_red;
                res.cb_offset    = yuv_bus.cb_offset;
                res.cr_offset    = yuv_bus.cr_offset;
                res.chroma_valid = yuv_bus.chroma_valid;
                res.frame_last   = yuv_bus.frame_last;
                tracker.check_yuv(res);
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if ((pix_bus.valid && pix_bus.ready) || (yuv_bus.valid && yuv_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, tracker.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one pixel pair after an optional gap; valid stays high afterward
    task automatic send_pair(input logic [PIX_W-1:0] f0, f1, f2, s0, s1, s2);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_bus.valid      <= 1'b1;
        pix_bus.first_ch0  <= f0;
        pix_bus.first_ch1  <= f1;
        pix_bus.first_ch2  <= f2;
        pix_bus.second_ch0 <= s0;
        pix_bus.second_ch1 <= s1;
        pix_bus.second_ch2 <= s2;
        do @(posedge clk); while (!pix_bus.ready);
    endtask

    // Hold until every expected result has been taken
    task automatic wait_idle();
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic write_reg(input rty_pkg::cfg_idx_t idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    // Reprogram all registers once the block has drained
    task automatic configure(input logic [CFG_DATA_W-1:0] w, h, input bit swap, flip);
        wait_idle();
        write_reg(rty_pkg::CFG_FRAME_WIDTH, w);
        write_reg(rty_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(rty_pkg::CFG_SWAP_RB, CFG_DATA_W'(swap));
        write_reg(rty_pkg::CFG_FLIP_VERT, CFG_DATA_W'(flip));
        cfg_bus.valid <= 1'b0;
    endtask

    // Random channel byte, biased toward the extremes
    function automatic logic [PIX_W-1:0] rand_channel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Random frame dimension: mostly small frames, sometimes any 13-bit value
    function automatic logic [CFG_DATA_W-1:0] rand_dim(input bit is_width);
        if ($urandom_range(3) != 0)
            return is_width ? CFG_DATA_W'($urandom_range(1, 10) * 2)
                            : CFG_DATA_W'($urandom_range(1, 7));
        return CFG_DATA_W'($urandom_range(8191));
    endfunction

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input bit squeeze);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (squeeze)
            hold_request = 1'b1;
        repeat (count)
            send_pair(rand_channel(), rand_channel(), rand_channel(),
                      rand_channel(), rand_channel(), rand_channel());
        pix_bus.valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic [CFG_DATA_W-1:0] cfg_w, cfg_h;
        bit                    cfg_swap, cfg_flip;
        int                    idle_pct, stall_pct;

        rst_n              <= 1'b0;
        pix_bus.valid      <= 1'b0;
        pix_bus.first_ch0  <= '0;
        pix_bus.first_ch1  <= '0;
        pix_bus.first_ch2  <= '0;
        pix_bus.second_ch0 <= '0;
        pix_bus.second_ch1 <= '0;
        pix_bus.second_ch2 <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= rty_pkg::CFG_FRAME_WIDTH;
        cfg_bus.data       <= '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        hold_left          = 0;
        quiet_cycles       = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry, then color extremes on a 4x3 frame
        send_pair(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60);
        send_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
        pix_bus.valid <= 1'b0;
        configure(13'd4, 13'd3, 1'b0, 1'b0);
        send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
        send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0);
        send_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255);
        send_pair(8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255);
        send_pair(8'd1, 8'd2, 8'd3, 8'd254, 8'd253, 8'd252);
        send_pair(8'd128, 8'd127, 8'd64, 8'd85, 8'd170, 8'd15);
        pix_bus.valid <= 1'b0;

        // Odd width rounds down, channels swapped, rows flipped
        configure(13'd5, 13'd3, 1'b1, 1'b1);
        send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
        send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_pair(8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102);
        pix_bus.valid <= 1'b0;

        // Width below two and zero height: one pair per frame
        configure(13'd1, 13'd0, 1'b0, 1'b1);
        send_pair(8'd200, 8'd100, 8'd50, 8'd25, 8'd12, 8'd6);
        send_pair(8'd6, 8'd12, 8'd25, 8'd50, 8'd100, 8'd200);
        pix_bus.valid <= 1'b0;

        // Oversized frame saturates; flipped rows give the largest offsets
        configure(13'd8191, 13'd8191, 1'b0, 1'b1);
        send_pair(8'd90, 8'd180, 8'd45, 8'd135, 8'd225, 8'd15);
        send_pair(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
        send_pair(8'd33, 8'd66, 8'd99, 8'd132, 8'd165, 8'd198);
        pix_bus.valid <= 1'b0;

        // Shrink mid-frame: the column beyond the new width restarts at zero
        configure(13'd4, 13'd2, 1'b0, 1'b0);
        send_pair(8'd77, 8'd88, 8'd99, 8'd11, 8'd22, 8'd33);
        send_pair(8'd240, 8'd15, 8'd240, 8'd15, 8'd240, 8'd15);
        pix_bus.valid <= 1'b0;

        // Random phases over settings and handshake pacing
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            cfg_swap = $urandom_range(1);
            cfg_flip = $urandom_range(1);
            case (p)
                0:
                begin
                    cfg_w = 13'd2;
                    cfg_h = 13'd1;
                end
                1:
                begin
                    cfg_w    = 13'd4096;
                    cfg_h    = 13'd4096;
                    cfg_flip = 1'b1;
                end
                2:
                begin
                    cfg_w = 13'd8191;
                    cfg_h = 13'd8191;
                end
                3:
                begin
                    cfg_w = 13'd0;
                    cfg_h = 13'd0;
                end
                4:
                begin
                    cfg_w = rty_pkg::WIDTH_RESET;
                    cfg_h = rty_pkg::HEIGHT_RESET;
                end
                default:
                begin
                    cfg_w = rand_dim(1'b1);
                    cfg_h = rand_dim(1'b0);
                end
            endcase
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    idle_pct  = 34;
                    stall_pct = 34;
                end
            endcase
            configure(cfg_w, cfg_h, cfg_swap, cfg_flip);
            run_phase(PHASE_PAIRS, idle_pct, stall_pct, (p == 4) || (p == 8));
        end

        // Drain and report
        wait_idle();
        repeat (10) @(posedge clk);
        if (tracker.pending() != 0)
            $display("ERROR: %0d expected results never arrived", tracker.pending());
        $display("Converted %0d pixel pairs, %0d results checked, %0d frame ends, %0d chroma rows",
                 tracker.pairs_seen, tracker.results_checked, tracker.frame_ends,
                 tracker.chroma_rows);
        $display("Register writes: %0d; mismatches: %0d", tracker.reg_writes,
                 tracker.failures);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
